// File: rtl/bd_pkg.sv
// shared constants and elaboration-time helpers for the beckmann distribution pipeline
`timescale 1ns / 1ps
`default_nettype none
package bd_pkg;

  // quotient bits of |x| (Q.24 result, capped at 2^33)
  localparam int DIV_STEPS = 34;
  // fraction bits produced by the log2 squaring chain
  localparam int LOG_ITERS = 24;
  // fraction bits consumed by the exp2 product chain
  localparam int EXP_BITS  = 24;

  localparam logic [30:0] LOG2E_Q30  = 31'd1549082005;
  localparam logic [32:0] LOG2PI_Q24 = 33'd27707507;
  localparam logic [31:0] ONE_Q30    = 32'h4000_0000;

  // floor square root of a 64-bit value
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    rem  = v;
    res  = '0;
    bitv = 64'h4000_0000_0000_0000;
    for (int j = 0; j < 32; j++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // 2^(2^-n) as Q2.30 by repeated floor square roots from 2.0
  function automatic logic [31:0] exp2_root(input int n);
    logic [63:0] t;
    t = 64'h8000_0000;
    for (int k = 1; k <= 24; k++) begin
      if (k <= n) begin
        t = isqrt64(t << 30);
      end
    end
    return t[31:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/bd_div.sv
// pipelined restoring divider: floor(mag * 2^56 / dvs) with overflow flag
`timescale 1ns / 1ps
`default_nettype none
module bd_div (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] mag,
  input  wire logic [63:0] dvs,
  output logic [bd_pkg::DIV_STEPS-1:0] quo,
  output logic             sat
);

  localparam int QW = bd_pkg::DIV_STEPS;

  logic [63:0] rem  [QW+1];
  logic [63:0] dreg [QW+1];
  logic [QW-1:0] qreg [QW+1];
  logic        ovf  [QW+1];

  // top part of the dividend; quotient overflows 34 bits when it reaches the divisor
  logic [63:0] head;
  assign head = {10'd0, mag, 22'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= head;
      dreg[0] <= dvs;
      qreg[0] <= '0;
      ovf[0]  <= (head >= dvs);
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [64:0] dbl;
    logic [64:0] dif;
    logic        take;
    assign dbl  = {rem[i], 1'b0};
    assign dif  = dbl - {1'b0, dreg[i]};
    assign take = ~dif[64];
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]  <= take ? dif[63:0] : dbl[63:0];
        dreg[i+1] <= dreg[i];
        qreg[i+1] <= {qreg[i][QW-2:0], take};
        ovf[i+1]  <= ovf[i];
      end
    end
  end

  assign quo = qreg[QW];
  assign sat = ovf[QW];

endmodule
`default_nettype wire

// File: rtl/bd_log2.sv
// pipelined log2 of a 32-bit integer: leading one plus squaring chain
`timescale 1ns / 1ps
`default_nettype none
module bd_log2 (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] val,
  output logic [4:0]       ipart,
  output logic [bd_pkg::LOG_ITERS-1:0] frac
);

  localparam int N = bd_pkg::LOG_ITERS;

  logic [30:0]  man  [N+1];
  logic [4:0]   pos  [N+1];
  logic [N-1:0] fr   [N+1];

  logic [4:0]  lead;
  logic [61:0] norm;

  always_comb begin
    lead = '0;
    for (int j = 0; j < 32; j++) begin
      if (val[j]) begin
        lead = 5'(j);
      end
    end
  end

  // leading one lands on bit 30, low bits truncated
  assign norm = {val, 30'd0} >> lead;

  always_ff @(posedge clk) begin
    if (en) begin
      man[0] <= norm[30:0];
      pos[0] <= lead;
      fr[0]  <= '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_sq
    logic [61:0] sq;
    logic        hi;
    assign sq = man[i] * man[i];
    assign hi = sq[61];
    always_ff @(posedge clk) begin
      if (en) begin
        man[i+1] <= hi ? sq[61:31] : sq[60:30];
        pos[i+1] <= pos[i];
        fr[i+1]  <= {fr[i][N-2:0], hi};
      end
    end
  end

  assign ipart = pos[N];
  assign frac  = fr[N];

endmodule
`default_nettype wire

// File: rtl/bd_exp2.sv
// pipelined 2^f for a 24-bit fraction, Q2.30 result, one root factor per stage
`timescale 1ns / 1ps
`default_nettype none
module bd_exp2 (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [bd_pkg::EXP_BITS-1:0] frac,
  output logic [31:0]      man
);

  localparam int N = bd_pkg::EXP_BITS;

  logic [31:0]  mreg [N];
  logic [N-1:0] freg [N];

  for (genvar i = 0; i < N; i++) begin : g_mul
    localparam logic [31:0] ROOT = bd_pkg::exp2_root(i + 1);
    logic [31:0]  msrc;
    logic [N-1:0] fsrc;
    logic [63:0]  prod;
    if (i == 0) begin : g_first
      assign msrc = bd_pkg::ONE_Q30;
      assign fsrc = frac;
    end else begin : g_next
      assign msrc = mreg[i-1];
      assign fsrc = freg[i-1];
    end
    assign prod = msrc * ROOT + 64'h2000_0000;
    always_ff @(posedge clk) begin
      if (en) begin
        mreg[i] <= fsrc[N-1-i] ? prod[61:30] : msrc;
        freg[i] <= fsrc;
      end
    end
  end

  assign man = mreg[N-1];

endmodule
`default_nettype wire

// File: rtl/beckmann_distribution.sv
// top level of the beckmann microfacet distribution evaluator
//
//  channel   dir  fields (lsb first)                                     width
//  s_axis    in   roughness, normal_x/y/z, half_x/y/z                    112
//  m_axis    out  density (unsigned q16.16)                               32
//
// one request enters per cycle while s_axis_tready is high; from accept to result
// a request passes the 34-stage divider chain and the 24-stage exp2 product chain
// a two-entry output buffer sits after the pipeline; the whole pipeline
// freezes only when both entries hold results, so s_axis_tready is a register
// rst is synchronous and clears the valid chain and the output buffer
`timescale 1ns / 1ps
`default_nettype none
module beckmann_distribution (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // roughness[15:0], normal_x[31:16], normal_y[47:32], normal_z[63:48],
  // half_x[79:64], half_y[95:80], half_z[111:96]
  input  wire logic [111:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // density[31:0]
  output logic [31:0]       m_axis_tdata
);

  localparam int LAT_DIV = bd_pkg::DIV_STEPS + 1;
  localparam int LAT_LOG = bd_pkg::LOG_ITERS + 1;
  localparam int LAT_EXP = bd_pkg::EXP_BITS;
  // stage numbers: divider fed at 5, result of z classification at 42
  localparam int T_ZCL  = 5 + LAT_DIV + 2;
  localparam int T_LAST = T_ZCL + LAT_EXP;
  localparam int DLY_L  = LAT_DIV - LAT_LOG;

  logic en;
  logic [T_LAST:1] vld;

  // output buffer
  logic        ob_valid;
  logic [31:0] ob_data;
  logic        sk_valid;
  logic [31:0] sk_data;

  assign en            = ~sk_valid;
  assign s_axis_tready = en;

  // field unpack
  logic [15:0]        rough;
  logic signed [15:0] nx, ny, nz, hx, hy, hz;
  assign rough = s_axis_tdata[15:0];
  assign nx    = s_axis_tdata[31:16];
  assign ny    = s_axis_tdata[47:32];
  assign nz    = s_axis_tdata[63:48];
  assign hx    = s_axis_tdata[79:64];
  assign hy    = s_axis_tdata[95:80];
  assign hz    = s_axis_tdata[111:96];

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[T_LAST-1:1], s_axis_tvalid};
    end
  end

  // stage 1: component products and alpha squared (zero alpha taken as one)
  logic signed [31:0] p0, p1, p2;
  logic [31:0]        a2_1;
  logic [15:0]        a_eff;
  assign a_eff = (rough == 16'd0) ? 16'd1 : rough;

  always_ff @(posedge clk) begin
    if (en) begin
      p0   <= nx * hx;
      p1   <= ny * hy;
      p2   <= nz * hz;
      a2_1 <= a_eff * a_eff;
    end
  end

  // stage 2: c = n.h in q2.30
  logic signed [33:0] csum;
  logic [31:0]        cmag;
  logic               pos2;
  logic [31:0]        a2_2;
  assign csum = 34'(p0) + 34'(p1) + 34'(p2);

  always_ff @(posedge clk) begin
    if (en) begin
      cmag <= csum[31:0];
      pos2 <= ~csum[33] && (csum != '0);
      a2_2 <= a2_1;
    end
  end

  // stage 3: c squared
  logic [63:0] csq;
  logic        pos3;
  logic [31:0] a2_3;

  always_ff @(posedge clk) begin
    if (en) begin
      csq  <= cmag * cmag;
      pos3 <= pos2;
      a2_3 <= a2_2;
    end
  end

  // stage 4: s = c^2 in q4.28, rounded half up
  logic [63:0] csq_rnd;
  logic [31:0] s4;
  logic        ok4;
  logic [31:0] a2_4;
  assign csq_rnd = csq + 64'h8000_0000;

  always_ff @(posedge clk) begin
    if (en) begin
      s4   <= csq_rnd[63:32];
      ok4  <= pos3 && (csq_rnd[63:32] != '0);
      a2_4 <= a2_3;
    end
  end

  // stage 5: divisor s*a^2 and |s - 1.0|
  logic signed [32:0] dlt;
  logic [63:0]        dvs;
  logic [31:0]        mag;
  logic               neg5;
  logic               ok5;
  assign dlt = $signed({1'b0, s4}) - 33'sh1000_0000;

  always_ff @(posedge clk) begin
    if (en) begin
      dvs  <= s4 * a2_4;
      mag  <= dlt[32] ? 32'(-dlt) : dlt[31:0];
      neg5 <= dlt[32];
      ok5  <= ok4;
    end
  end

  // log2 of a^2 and s run beside the divider
  logic [4:0]  la_i, ls_i;
  logic [23:0] la_f, ls_f;

  bd_log2 u_log_a (
    .clk   (clk),
    .en    (en),
    .val   (a2_4),
    .ipart (la_i),
    .frac  (la_f)
  );

  bd_log2 u_log_s (
    .clk   (clk),
    .en    (en),
    .val   (s4),
    .ipart (ls_i),
    .frac  (ls_f)
  );

  // constant part of the exponent: 16 - log2(pi) - (log2 a2 - 32) - 2(log2 s - 28)
  logic signed [32:0] lsum;
  logic [32:0]        la_v, ls_v;
  assign la_v = {4'd0, la_i, la_f};
  assign ls_v = {4'd0, ls_i, ls_f};

  always_ff @(posedge clk) begin
    if (en) begin
      lsum <= $signed(33'd104 << 24) - $signed(bd_pkg::LOG2PI_Q24)
              - $signed(la_v) - $signed(ls_v << 1);
    end
  end

  logic signed [32:0] l_dly [DLY_L];
  always_ff @(posedge clk) begin
    if (en) begin
      l_dly[0] <= lsum;
      for (int i = 1; i < DLY_L; i++) begin
        l_dly[i] <= l_dly[i-1];
      end
    end
  end

  // divider: |x| = |s - 1| / (s a^2) in q.24
  logic [bd_pkg::DIV_STEPS-1:0] quo;
  logic                         qsat;

  bd_div u_div (
    .clk (clk),
    .en  (en),
    .mag (mag),
    .dvs (dvs),
    .quo (quo),
    .sat (qsat)
  );

  logic [1:0] fl_dly [LAT_DIV];
  always_ff @(posedge clk) begin
    if (en) begin
      fl_dly[0] <= {ok5, neg5};
      for (int i = 1; i < LAT_DIV; i++) begin
        fl_dly[i] <= fl_dly[i-1];
      end
    end
  end

  // stage after divider: e = |x| log2(e), cap at 2^33 first
  localparam logic [bd_pkg::DIV_STEPS-1:0] X_CAP = 34'h2_0000_0000;
  logic [33:0]        xcap;
  logic [64:0]        eprod;
  logic [34:0]        ev;
  logic               ok41, neg41;
  logic signed [32:0] l41;
  assign xcap  = (qsat || quo > X_CAP) ? X_CAP : quo;
  assign eprod = xcap * bd_pkg::LOG2E_Q30 + 65'h2000_0000;

  always_ff @(posedge clk) begin
    if (en) begin
      ev    <= eprod[64:30];
      ok41  <= fl_dly[LAT_DIV-1][1];
      neg41 <= fl_dly[LAT_DIV-1][0];
      l41   <= l_dly[DLY_L-1];
    end
  end

  // z = log2 of the q16.16 result; split into integer step and fraction
  logic signed [37:0] zv, zz;
  logic               zhi, zlo;
  assign zv  = neg41 ? (38'(l41) - $signed({3'd0, ev})) : (38'(l41) + $signed({3'd0, ev}));
  assign zhi = zv >= $signed(38'h2000_0000);
  assign zlo = zv < -$signed(38'h100_0000);
  assign zz  = zv + $signed(38'h100_0000);

  logic [5:0]  kk;
  logic [23:0] zf;
  logic        norm42, sat42;

  always_ff @(posedge clk) begin
    if (en) begin
      kk     <= zz[29:24];
      zf     <= zz[23:0];
      norm42 <= ok41 && !zhi && !zlo;
      sat42  <= ok41 && zhi;
    end
  end

  logic [7:0] ex_dly [LAT_EXP];
  always_ff @(posedge clk) begin
    if (en) begin
      ex_dly[0] <= {kk, norm42, sat42};
      for (int i = 1; i < LAT_EXP; i++) begin
        ex_dly[i] <= ex_dly[i-1];
      end
    end
  end

  logic [31:0] man;
  bd_exp2 u_exp (
    .clk  (clk),
    .en   (en),
    .frac (zf),
    .man  (man)
  );

  // final scale: mantissa by 2^(kk-1) with round half up, as (2m + half) >> (32 - kk)
  logic [5:0]  kf, sh;
  logic        normf, satf;
  logic [33:0] wide, rnd, shifted;
  logic [31:0] res;
  assign kf      = ex_dly[LAT_EXP-1][7:2];
  assign normf   = ex_dly[LAT_EXP-1][1];
  assign satf    = ex_dly[LAT_EXP-1][0];
  assign sh      = 6'd32 - kf;
  assign wide    = {1'b0, man, 1'b0};
  assign rnd     = (sh == 6'd0) ? 34'd0 : (34'd1 << (sh - 6'd1));
  assign shifted = (wide + rnd) >> sh;

  always_comb begin
    if (normf) begin
      res = (shifted[33:32] != 2'd0) ? 32'hFFFF_FFFF : shifted[31:0];
    end else if (satf) begin
      res = 32'hFFFF_FFFF;
    end else begin
      res = '0;
    end
  end

  // output buffer: main entry plus skid entry
  logic push, pop;
  assign push = en & vld[T_LAST];
  assign pop  = ob_valid & m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_valid <= 1'b0;
      sk_valid <= 1'b0;
    end else begin
      if (pop || !ob_valid) begin
        if (sk_valid) begin
          ob_valid <= 1'b1;
          sk_valid <= 1'b0;
        end else begin
          ob_valid <= push;
        end
      end else if (push) begin
        sk_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !ob_valid) begin
      ob_data <= sk_valid ? sk_data : res;
    end
    if (ob_valid && !pop && push) begin
      sk_data <= res;
    end
  end

  assign m_axis_tvalid = ob_valid;
  assign m_axis_tdata  = ob_data;

endmodule
`default_nettype wire
